>>> design/rht_pkg.sv
// ----------------------------------------------------------------------------
// rht_pkg
// Types and constants shared by the reference-counted handle table.
// ----------------------------------------------------------------------------
package rht_pkg;

	localparam int SLOTS_DEF = 32;
	localparam int SLOT_W    = 5;
	localparam int KEY_W     = 16;
	localparam int CNT_W     = 8;

	localparam logic [1:0] CMD_GET    = 2'd0;
	localparam logic [1:0] CMD_PUT    = 2'd1;
	localparam logic [1:0] CMD_LOCK   = 2'd2;
	localparam logic [1:0] CMD_UNLOCK = 2'd3;

	localparam logic [1:0] ST_HIT  = 2'd0;
	localparam logic [1:0] ST_NEW  = 2'd1;
	localparam logic [1:0] ST_BUSY = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic [KEY_W-1:0] device;
		logic [KEY_W-1:0] number;
		logic [CNT_W-1:0] refcount;
		logic             locked;
		logic             wanted;
	} entry_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
		logic              wake;
		logic              last;
		logic              release_st;
	} result_t;

endpackage

>>> design/rht_engine.sv
// ----------------------------------------------------------------------------
// rht_engine
// Slot memory with its sequencer: clearing pass, key scan for get, and
// read-modify-write of one slot for put, lock and unlock.
// ----------------------------------------------------------------------------
module rht_engine #(
	parameter int SLOTS = rht_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 command,
	input  logic [rht_pkg::KEY_W-1:0]  device_id,
	input  logic [rht_pkg::KEY_W-1:0]  object_number,
	input  logic [rht_pkg::SLOT_W-1:0] slot_index,
	input  logic                       no_links,
	input  logic                       room,
	output logic                       push,
	output rht_pkg::result_t           res
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_MOD   = 5'b00100,
		S_SCAN  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q;

	rht_pkg::entry_t mem_q [SLOTS];
	rht_pkg::entry_t rdata_s1;
	logic            rd_s1;
	logic [IDX_W-1:0] addr_s1;

	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] idx_q;
	logic             issued_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [IDX_W-1:0] addr_q;
	logic [1:0]       cmd_q;
	logic [rht_pkg::KEY_W-1:0] dev_q;
	logic [rht_pkg::KEY_W-1:0] num_q;
	logic             nolink_q;
	rht_pkg::result_t res_q;

	logic             accept;
	logic             slot_ok;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	rht_pkg::entry_t  mem_wdata;
	logic             finish;
	rht_pkg::result_t res_d;
	logic             hit;
	logic             rd_free;
	logic [rht_pkg::CNT_W-1:0] cnt_dec;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);
	assign slot_ok  = (32'(slot_index) < SLOTS);
	assign push     = (state_q == S_DONE) && room;
	assign res      = res_q;

	assign hit     = rd_s1 && (rdata_s1.device == dev_q) && (rdata_s1.number == num_q);
	assign rd_free = rd_s1 && (rdata_s1.refcount == '0);
	assign cnt_dec = (rdata_s1.refcount != '0) ? (rdata_s1.refcount - 1'b1) : '0;

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = IDX_W'(slot_index);
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = rdata_s1;
		finish    = 1'b0;
		res_d     = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_IDLE: begin
				mem_re = accept && (command != rht_pkg::CMD_GET) && slot_ok;
				if (accept && (command != rht_pkg::CMD_GET) && !slot_ok) begin
					finish       = 1'b1;
					res_d.status = rht_pkg::ST_FULL;
					res_d.slot   = slot_index;
				end
			end
			S_MOD: begin
				finish     = 1'b1;
				res_d.slot = rht_pkg::SLOT_W'(addr_q);
				case (cmd_q)
					rht_pkg::CMD_PUT: begin
						mem_we             = 1'b1;
						mem_wdata.refcount = cnt_dec;
						mem_wdata.locked   = 1'b0;
						mem_wdata.wanted   = 1'b0;
						if (cnt_dec == '0) begin
							mem_wdata.number = '0;
							res_d.last       = 1'b1;
							res_d.release_st = nolink_q;
						end else begin
							res_d.wake = rdata_s1.wanted;
						end
					end
					rht_pkg::CMD_LOCK: begin
						if (rdata_s1.locked) begin
							res_d.status = rht_pkg::ST_BUSY;
						end else begin
							mem_we           = 1'b1;
							mem_wdata.locked = 1'b1;
						end
					end
					default: begin
						mem_we           = 1'b1;
						mem_wdata.locked = 1'b0;
						mem_wdata.wanted = 1'b0;
						res_d.wake       = rdata_s1.wanted;
					end
				endcase
			end
			S_SCAN: begin
				mem_re    = !issued_q;
				mem_raddr = idx_q;
				res_d.slot = rht_pkg::SLOT_W'(addr_s1);
				if (hit) begin
					finish    = 1'b1;
					mem_we    = 1'b1;
					mem_waddr = addr_s1;
					if (rdata_s1.locked) begin
						mem_wdata.wanted = 1'b1;
						res_d.status     = rht_pkg::ST_BUSY;
					end else begin
						mem_wdata.locked = 1'b1;
						if (rdata_s1.refcount != rht_pkg::CNT_MAX) begin
							mem_wdata.refcount = rdata_s1.refcount + 1'b1;
						end
					end
				end else if (rd_s1 && (addr_s1 == LAST_IDX)) begin
					finish = 1'b1;
					if (free_q || rd_free) begin
						mem_we             = 1'b1;
						mem_waddr          = free_q ? free_idx_q : addr_s1;
						mem_wdata.device   = dev_q;
						mem_wdata.number   = num_q;
						mem_wdata.refcount = rht_pkg::CNT_W'(1);
						mem_wdata.locked   = 1'b1;
						mem_wdata.wanted   = 1'b0;
						res_d.status       = rht_pkg::ST_NEW;
						res_d.slot         = rht_pkg::SLOT_W'(mem_waddr);
					end else begin
						res_d.status = rht_pkg::ST_FULL;
						res_d.slot   = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem_q[mem_raddr];
		end
		addr_s1 <= mem_raddr;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= command;
			dev_q    <= device_id;
			num_q    <= object_number;
			addr_q   <= IDX_W'(slot_index);
			nolink_q <= no_links;
		end
		if (state_q == S_SCAN && rd_free && !free_q) begin
			free_idx_q <= addr_s1;
		end
		if (finish) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			idx_q    <= '0;
			issued_q <= 1'b0;
			free_q   <= 1'b0;
			rd_s1    <= 1'b0;
		end else begin
			rd_s1 <= (state_q == S_SCAN) && mem_re;
			case (state_q)
				S_CLEAR: begin
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						idx_q    <= '0;
						issued_q <= 1'b0;
						free_q   <= 1'b0;
						if (command == rht_pkg::CMD_GET) begin
							state_q <= S_SCAN;
						end else if (slot_ok) begin
							state_q <= S_MOD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_MOD: begin
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (!issued_q) begin
						if (idx_q == LAST_IDX) begin
							issued_q <= 1'b1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					if (rd_free) begin
						free_q <= 1'b1;
					end
					if (finish) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (room) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/rht_out.sv
// ----------------------------------------------------------------------------
// rht_out
// Output register of the handle table; holds one result until it is taken.
// ----------------------------------------------------------------------------
module rht_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  rht_pkg::result_t           res,
	output logic                       room,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic [rht_pkg::SLOT_W-1:0] result_slot,
	output logic                       wake_waiters,
	output logic                       last_reference,
	output logic                       release_storage
);

	logic             valid_q;
	rht_pkg::result_t data_q;

	assign room            = !valid_q || !out_stall;
	assign out_valid       = valid_q;
	assign status          = data_q.status;
	assign result_slot     = data_q.slot;
	assign wake_waiters    = data_q.wake;
	assign last_reference  = data_q.last;
	assign release_storage = data_q.release_st;

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule

>>> design/refcounted_handle_table_top.sv
// ----------------------------------------------------------------------------
// refcounted_handle_table_top
// Reference-counted handle table: get, put, lock and unlock on a table of
// slots kept in one synchronous memory.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid / in_stall  command, device_id, object_number,
//                                           slot_index, no_links
//  out      output     out_valid / out_stall status, result_slot, wake_waiters,
//                                           last_reference, release_storage
//
// A get scans the memory one slot per cycle up to a match or the last slot.
// Put, lock and unlock read and write one slot.
// After reset a clearing pass over every slot runs before the first transaction.
// A result waits in the output register; the next transaction is taken while
// it waits, and only the hand-over of a further result stalls on out_stall.
module refcounted_handle_table_top #(
	parameter int SLOTS = rht_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 command,
	input  logic [rht_pkg::KEY_W-1:0]  device_id,
	input  logic [rht_pkg::KEY_W-1:0]  object_number,
	input  logic [rht_pkg::SLOT_W-1:0] slot_index,
	input  logic                       no_links,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic [rht_pkg::SLOT_W-1:0] result_slot,
	output logic                       wake_waiters,
	output logic                       last_reference,
	output logic                       release_storage
);

	logic             room;
	logic             push;
	rht_pkg::result_t res;

	rht_engine #(
		.SLOTS(SLOTS)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.device_id     (device_id),
		.object_number (object_number),
		.slot_index    (slot_index),
		.no_links      (no_links),
		.room          (room),
		.push          (push),
		.res           (res)
	);

	rht_out u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.res             (res),
		.room            (room),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.result_slot     (result_slot),
		.wake_waiters    (wake_waiters),
		.last_reference  (last_reference),
		.release_storage (release_storage)
	);

endmodule

>>> design/rht_checker.sv
// ----------------------------------------------------------------------------
// rht_port_checks
// Port-level checks for the handle table, attached to the top level.
// ----------------------------------------------------------------------------
module rht_port_checks (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [1:0]                 status,
	input logic [rht_pkg::SLOT_W-1:0] result_slot,
	input logic                       wake_waiters,
	input logic                       last_reference,
	input logic                       release_storage
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after a transaction");

	a_flags_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != rht_pkg::ST_HIT) |->
		(!wake_waiters && !last_reference && !release_storage))
		else $error("flags set on a result that is not ok");

	a_release_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && release_storage) |-> (last_reference && !wake_waiters))
		else $error("storage release without last reference");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(result_slot)))
		else $error("stalled result changed");

endmodule

bind refcounted_handle_table_top rht_port_checks u_rht_port_checks (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.status          (status),
	.result_slot     (result_slot),
	.wake_waiters    (wake_waiters),
	.last_reference  (last_reference),
	.release_storage (release_storage)
);

>>> test/rht_checker.sv
// ----------------------------------------------------------------------------
// rht_checker
// Watches both channels of the handle table. It keeps a shadow copy of every
// slot, predicts the result of each accepted transaction, and compares each
// returned result field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module rht_checker #(
	parameter int SLOTS = rht_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [1:0]                 command,
	input  logic [rht_pkg::KEY_W-1:0]  device_id,
	input  logic [rht_pkg::KEY_W-1:0]  object_number,
	input  logic [rht_pkg::SLOT_W-1:0] slot_index,
	input  logic                       no_links,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [1:0]                 status,
	input  logic [rht_pkg::SLOT_W-1:0] result_slot,
	input  logic                       wake_waiters,
	input  logic                       last_reference,
	input  logic                       release_storage,
	output int                         mismatches,
	output int                         outstanding
);
	import rht_pkg::*;

	entry_t  shadow_slots [SLOTS];
	result_t expected_results [$];
	result_t oldest;
	int      error_total;
	int      result_index;

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		error_total++;
		if (error_total <= 40)
			$display("rht_checker: result %0d: %s: got %0h, expected %0h",
				result_index, what, got, want);
	endtask

	function automatic result_t apply_to_table(logic [1:0] cmd, logic [KEY_W-1:0] dev,
		logic [KEY_W-1:0] num, logic [SLOT_W-1:0] idx, logic no_link);
		result_t outcome;
		int      hit_slot;
		int      free_slot;
		int      s;
		outcome   = '0;
		hit_slot  = -1;
		free_slot = -1;
		s         = int'(idx);
		if (cmd == CMD_GET) begin
			// Scanning downward leaves the lowest matching and lowest free slot.
			for (int i = SLOTS - 1; i >= 0; i--) begin
				if (shadow_slots[i].device == dev && shadow_slots[i].number == num)
					hit_slot = i;
				if (shadow_slots[i].refcount == '0)
					free_slot = i;
			end
			if (hit_slot >= 0) begin
				outcome.slot = hit_slot[SLOT_W-1:0];
				if (shadow_slots[hit_slot].locked) begin
					shadow_slots[hit_slot].wanted = 1'b1;
					outcome.status = ST_BUSY;
				end else begin
					if (shadow_slots[hit_slot].refcount != CNT_MAX)
						shadow_slots[hit_slot].refcount = shadow_slots[hit_slot].refcount + 1'b1;
					shadow_slots[hit_slot].locked = 1'b1;
					outcome.status = ST_HIT;
				end
			end else if (free_slot >= 0) begin
				shadow_slots[free_slot] = {dev, num, CNT_W'(1), 1'b1, 1'b0};
				outcome.status = ST_NEW;
				outcome.slot   = free_slot[SLOT_W-1:0];
			end else begin
				outcome.status = ST_FULL;
			end
		end else if (s >= SLOTS) begin
			outcome.status = ST_FULL;
			outcome.slot   = idx;
		end else if (cmd == CMD_PUT) begin
			outcome.status = ST_HIT;
			outcome.slot   = idx;
			if (shadow_slots[s].refcount != '0)
				shadow_slots[s].refcount = shadow_slots[s].refcount - 1'b1;
			if (shadow_slots[s].refcount == '0) begin
				outcome.last       = 1'b1;
				outcome.release_st = no_link;
				shadow_slots[s].number = '0;
			end else begin
				outcome.wake = shadow_slots[s].wanted;
			end
			shadow_slots[s].locked = 1'b0;
			shadow_slots[s].wanted = 1'b0;
		end else if (cmd == CMD_LOCK) begin
			outcome.slot = idx;
			if (shadow_slots[s].locked) begin
				outcome.status = ST_BUSY;
			end else begin
				shadow_slots[s].locked = 1'b1;
				outcome.status = ST_HIT;
			end
		end else begin
			outcome.status = ST_HIT;
			outcome.slot   = idx;
			outcome.wake   = shadow_slots[s].wanted;
			shadow_slots[s].locked = 1'b0;
			shadow_slots[s].wanted = 1'b0;
		end
		return outcome;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (shadow_slots[i])
				shadow_slots[i] = '0;
			expected_results.delete();
			error_total  = 0;
			result_index = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected, status", 32'(status), '0);
				end else begin
					oldest = expected_results.pop_front();
					if (status !== oldest.status)
						report_mismatch("status", 32'(status), 32'(oldest.status));
					if (result_slot !== oldest.slot)
						report_mismatch("result_slot", 32'(result_slot), 32'(oldest.slot));
					if (wake_waiters !== oldest.wake)
						report_mismatch("wake_waiters", 32'(wake_waiters), 32'(oldest.wake));
					if (last_reference !== oldest.last)
						report_mismatch("last_reference", 32'(last_reference),
							32'(oldest.last));
					if (release_storage !== oldest.release_st)
						report_mismatch("release_storage", 32'(release_storage),
							32'(oldest.release_st));
				end
				result_index++;
			end
			if (in_valid && !in_stall)
				expected_results.push_back(apply_to_table(command, device_id, object_number,
					slot_index, no_links));
			mismatches  <= error_total;
			outstanding <= expected_results.size();
		end
	end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives get, put, lock and unlock transactions into the handle table under
// several idle and stall patterns: a directed opening, random traffic that
// fills and drains the table, and a run that takes one key past the count
// limit. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
	import rht_pkg::*;

	localparam int SLOTS          = SLOTS_DEF;
	localparam int CLK_HALF       = 6;
	localparam int TIMEOUT_CYCLES = 800000;
	localparam logic [KEY_W-1:0] HOT_DEV = 16'hC0DE;
	localparam logic [KEY_W-1:0] HOT_NUM = 16'h0042;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              in_valid      = 1'b0;
	logic              in_stall;
	logic [1:0]        command       = CMD_GET;
	logic [KEY_W-1:0]  device_id     = '0;
	logic [KEY_W-1:0]  object_number = '0;
	logic [SLOT_W-1:0] slot_index    = '0;
	logic              no_links      = 1'b0;
	logic              out_valid;
	logic              out_stall     = 1'b0;
	logic [1:0]        status;
	logic [SLOT_W-1:0] result_slot;
	logic              wake_waiters;
	logic              last_reference;
	logic              release_storage;
	int                mismatches;
	int                outstanding;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int n_get         = 0;
	int n_put         = 0;
	int n_lock        = 0;
	int n_unlock      = 0;
	int pump_rounds   = 0;

	refcounted_handle_table_top #(.SLOTS(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .device_id(device_id), .object_number(object_number),
		.slot_index(slot_index), .no_links(no_links),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .result_slot(result_slot), .wake_waiters(wake_waiters),
		.last_reference(last_reference), .release_storage(release_storage)
	);

	rht_checker #(.SLOTS(SLOTS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .device_id(device_id), .object_number(object_number),
		.slot_index(slot_index), .no_links(no_links),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .result_slot(result_slot), .wake_waiters(wake_waiters),
		.last_reference(last_reference), .release_storage(release_storage),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		#(2 * CLK_HALF * TIMEOUT_CYCLES);
		$display("tb_top: FAIL");
		$finish;
	end

	task automatic send_cmd(logic [1:0] cmd, logic [KEY_W-1:0] dev, logic [KEY_W-1:0] num,
		logic [SLOT_W-1:0] idx, logic no_link);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		command       <= cmd;
		device_id     <= dev;
		object_number <= num;
		slot_index    <= idx;
		no_links      <= no_link;
		do @(posedge clk); while (in_stall);
		case (cmd)
			CMD_GET: n_get++;
			CMD_PUT: n_put++;
			CMD_LOCK: n_lock++;
			default: n_unlock++;
		endcase
	endtask

	task automatic await_result(output logic [1:0] st, output logic [SLOT_W-1:0] slot);
		in_valid <= 1'b0;
		do @(posedge clk); while (!(out_valid && !out_stall));
		st   = status;
		slot = result_slot;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic random_batch(int count, int get_pct, int put_pct, int lock_pct);
		int                pick;
		int                key;
		logic [1:0]        cmd;
		logic [KEY_W-1:0]  dev;
		logic [KEY_W-1:0]  num;
		logic [SLOT_W-1:0] idx;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < get_pct)
				cmd = CMD_GET;
			else if (pick < get_pct + put_pct)
				cmd = CMD_PUT;
			else if (pick < get_pct + put_pct + lock_pct)
				cmd = CMD_LOCK;
			else
				cmd = CMD_UNLOCK;
			key = $urandom_range(47);
			dev = KEY_W'(key % 8);
			num = KEY_W'(key / 8);
			if ($urandom_range(7) == 0) begin
				dev = KEY_W'($urandom);
				num = KEY_W'($urandom);
			end
			if ($urandom_range(1) == 1)
				idx = SLOT_W'($urandom_range(31));
			else
				idx = SLOT_W'($urandom_range(7));
			send_cmd(cmd, dev, num, idx, 1'($urandom_range(1)));
		end
	endtask

	// Each round takes the hot key and releases its lock, so once the key is in the
	// table every get is a plain hit and the count climbs until it saturates.
	task automatic pump_hot_key(int rounds);
		logic [1:0]        st;
		logic [SLOT_W-1:0] slot;
		while (pump_rounds < rounds) begin
			send_cmd(CMD_GET, HOT_DEV, HOT_NUM, '0, 1'b0);
			await_result(st, slot);
			if (st == ST_FULL) begin
				send_cmd(CMD_PUT, '0, '0, SLOT_W'($urandom_range(31)), 1'($urandom_range(1)));
			end else begin
				send_cmd(CMD_UNLOCK, '0, '0, slot, 1'b0);
				pump_rounds++;
			end
			await_result(st, slot);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_cmd(CMD_PUT, '0, '0, 5'd31, 1'b1);
		send_cmd(CMD_GET, 16'h0000, 16'h0000, '0, 1'b0);
		send_cmd(CMD_GET, 16'h0000, 16'h0000, '0, 1'b0);
		send_cmd(CMD_UNLOCK, '0, '0, 5'd0, 1'b0);
		send_cmd(CMD_GET, 16'hFFFF, 16'hFFFF, 5'd31, 1'b1);
		send_cmd(CMD_LOCK, 16'hFFFF, 16'hFFFF, 5'd1, 1'b0);
		send_cmd(CMD_GET, 16'hFFFF, 16'hFFFF, '0, 1'b0);
		send_cmd(CMD_PUT, '0, '0, 5'd1, 1'b0);
		send_cmd(CMD_GET, 16'hFFFF, 16'h0000, '0, 1'b0);
		send_cmd(CMD_UNLOCK, '0, '0, 5'd1, 1'b0);
		send_cmd(CMD_LOCK, '0, '0, 5'd1, 1'b0);
		send_cmd(CMD_PUT, '0, '0, 5'd1, 1'b1);
		send_cmd(CMD_GET, 16'h1234, 16'hABCD, '0, 1'b0);
		send_cmd(CMD_UNLOCK, '0, '0, 5'd1, 1'b0);
		send_cmd(CMD_GET, 16'h1234, 16'hABCD, '0, 1'b0);
		send_cmd(CMD_GET, 16'h1234, 16'hABCD, '0, 1'b0);
		send_cmd(CMD_PUT, '0, '0, 5'd1, 1'b1);
		send_cmd(CMD_UNLOCK, '0, '0, 5'd31, 1'b0);
		send_cmd(CMD_LOCK, '0, '0, 5'd31, 1'b0);
		send_cmd(CMD_UNLOCK, '0, '0, 5'd31, 1'b0);
		send_cmd(CMD_GET, 16'h8000, 16'h0001, '0, 1'b0);
		send_cmd(CMD_GET, 16'h0001, 16'h8000, '0, 1'b0);
		send_cmd(CMD_PUT, '0, '0, 5'd0, 1'b0);

		random_batch(230, 45, 15, 10);
		send_idle_pct = 71;
		random_batch(230, 20, 45, 10);
		wait_drained();

		send_idle_pct = 25;
		stall_pct    <= 25;
		pump_hot_key(270);

		send_idle_pct = 0;
		stall_pct    <= 71;
		random_batch(230, 50, 10, 10);
		send_idle_pct = 25;
		stall_pct    <= 25;
		random_batch(230, 35, 30, 10);

		wait_drained();
		repeat (SLOTS + 8) @(posedge clk);
		$display("tb_top: drove %0d gets, %0d puts, %0d locks and %0d unlocks",
			n_get, n_put, n_lock, n_unlock);
		$display("tb_top: one key went through %0d get and unlock rounds past the count limit",
			pump_rounds);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
